>>> hdl/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the animation frame selector.
// ----------------------------------------------------------------------------
`default_nettype none

package afs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int ENTRY_W     = 33;
  localparam int OPER_W      = 17;

  // table entry layout
  localparam int ENT_ANIM    = 32;
  localparam int ENT_DUR_HI  = 31;
  localparam int ENT_DUR_LO  = 16;
  localparam int ENT_LOOP_HI = 15;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_PAST_END = 2'd2;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [OPER_W:0] diff;
    logic            ge;
    logic            gt;
  } afs_cmp_t;

endpackage

`default_nettype wire

>>> hdl/afs_ram.sv
// ----------------------------------------------------------------------------
// afs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/afs_sub.sv
// ----------------------------------------------------------------------------
// afs_sub
// Shared subtract/compare unit used by the remainder steps and the walk.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_sub
  import afs_pkg::*;
(
  input  wire logic [OPER_W-1:0] a,
  input  wire logic [OPER_W-1:0] b,
  output afs_cmp_t               cmp
);

  always_comb begin
    cmp.diff = {1'b0, a} - {1'b0, b};
    cmp.ge   = ~cmp.diff[OPER_W];
    cmp.gt   = cmp.ge && (cmp.diff != '0);
  end

endmodule

`default_nettype wire

>>> hdl/animation_frame_select.sv
// ----------------------------------------------------------------------------
// animation_frame_select
// Frame table with write and lookup; an animated lookup reduces time modulo
// the loop length, divides by 8 and walks forward over frame durations.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_*       in   tuser: func; tdata: entry_index, elapsed, animated,
//                 frame_duration, loop_length
//  m_*       out  tdata: frame_index, status
//  cfg_*     in   entry_count
//
//  A write passes S_IDLE and S_DONE; a non-animated lookup adds S_START.
//  An animated lookup adds a bit-serial remainder in S_DIV on the shared
//  subtractor, then S_WALK and S_WAIT per step, one table read per step.
//  rst clears control state; table contents stay undefined until written.
//  A stalled m side holds the result; the next beat is taken and then
//  waits with its own result until the held one leaves.
`default_nettype none

module animation_frame_select
  import afs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,  // entry_index[9:0], elapsed[41:10],
                                     // animated[42], frame_duration[58:43],
                                     // loop_length[74:59], zero[79:75]
  input  wire logic        s_tuser,  // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,  // frame_index[9:0], status[11:10]
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  logic [2:0]       state;
  logic [4:0]       cnt;
  logic [15:0]      rem;
  logic [15:0]      dvsr;
  logic [31:0]      tm;
  logic [12:0]      t;
  logic [IDX_W-1:0] walk_idx;
  logic [IDX_W-1:0] res_idx;
  logic [1:0]       res_status;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] next_idx;

  logic [IDX_W-1:0]   in_idx;
  logic               accept;
  logic               ram_we;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;
  logic [OPER_W-1:0]  op_a;
  logic [OPER_W-1:0]  op_b;
  afs_cmp_t           cmp;
  logic               out_free;

  assign in_idx    = s_tdata[9:0];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign ram_we    = accept && (s_tuser == FUNC_WRITE);
  assign wr_data   = {s_tdata[42], s_tdata[58:43], s_tdata[74:59]};
  assign rd_addr   = (state == S_IDLE) ? in_idx : walk_idx;
  assign count_eff = (entry_count > DEPTH_C) ? DEPTH_C : entry_count;
  assign next_idx  = {1'b0, walk_idx} + CNT_W'(1);
  assign out_free  = !m_tvalid || m_tready;

  afs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (in_idx),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // remainder step in S_DIV, remaining-time compare in S_WALK
  always_comb begin
    if (state == S_DIV) begin
      op_a = {rem, tm[31]};
      op_b = {1'b0, dvsr};
    end else begin
      op_a = {4'd0, t};
      op_b = {1'b0, rd_data[ENT_DUR_HI:ENT_DUR_LO]};
    end
  end

  afs_sub u_sub (
    .a   (op_a),
    .b   (op_b),
    .cmp (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // in S_DONE the reload below takes over the drained beat
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            walk_idx <= in_idx;
            tm       <= s_tdata[41:10];
            if (s_tuser == FUNC_WRITE) begin
              res_idx    <= '0;
              res_status <= ST_OK;
              state      <= S_DONE;
            end else if ({1'b0, in_idx} >= count_eff) begin
              res_idx    <= '0;
              res_status <= ST_RANGE;
              state      <= S_DONE;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          if (!rd_data[ENT_ANIM] || (rd_data[ENT_LOOP_HI:0] == '0)) begin
            res_idx    <= walk_idx;
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            dvsr  <= rd_data[ENT_LOOP_HI:0];
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one remainder bit per cycle, MSB first
          rem <= cmp.ge ? cmp.diff[15:0] : op_a[15:0];
          tm  <= {tm[30:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            t     <= cmp.ge ? cmp.diff[15:3] : op_a[15:3];
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (cmp.gt) begin
            t <= cmp.diff[12:0];
            if (next_idx >= count_eff) begin
              res_idx    <= '0;
              res_status <= ST_PAST_END;
              state      <= S_DONE;
            end else begin
              walk_idx <= next_idx[IDX_W-1:0];
              state    <= S_WAIT;
            end
          end else begin
            res_idx    <= walk_idx;
            res_status <= ST_OK;
            state      <= S_DONE;
          end
        end
        S_WAIT: begin
          // table read of the next entry in flight
          state <= S_WALK;
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata  <= {4'd0, res_status, res_idx};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[11:10] == ST_OK) || (m_tdata[11:10] == ST_RANGE) ||
                  (m_tdata[11:10] == ST_PAST_END)))
    else $error("status code out of range");

  a_error_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[11:10] != ST_OK)) |-> (m_tdata[9:0] == '0))
    else $error("error result with nonzero frame index");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ({1'b0, walk_idx} < count_eff))
    else $error("walk index beyond valid entries");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken while an item is in work");

endmodule

`default_nettype wire

>>> test/animation_frame_select_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_frame_select_test
// Self-checking bench for the frame selector. Drives write and lookup beats
// through the stream ports and compares each result beat in order with a
// typed value or one predicted from a private copy of the frame table and
// entry count. Starts with a short directed table, then random animation
// sequences and noise, over several entry-count settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module animation_frame_select_test;
  import afs_pkg::*;

  typedef struct packed {
    logic        func;
    logic [9:0]  idx;
    logic [31:0] ftime;
    logic        anim;
    logic [15:0] dur;
    logic [15:0] loop_len;
  } frame_req_t;

  typedef struct packed {
    logic [9:0] frame;
    logic [1:0] status;
  } frame_res_t;

  typedef struct packed {
    frame_res_t  res;
    logic [31:0] steps;
    logic        unwritten;
  } walk_t;

  typedef enum logic [1:0] {ROW_TYPED, ROW_PREDICTED, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    frame_req_t req;
    frame_res_t exp;
    logic [10:0] cfg;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [15:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  // private copy of the frame table
  bit          tbl_anim    [TABLE_DEPTH];
  bit   [15:0] tbl_dur     [TABLE_DEPTH];
  bit   [15:0] tbl_loop    [TABLE_DEPTH];
  bit          tbl_written [TABLE_DEPTH];
  int unsigned model_count = 0;

  frame_res_t  expected_frames[$];
  dir_row_t    dir_rows [22];

  int          errors = 0;
  int          n_writes = 0;
  int          n_lookups = 0;
  int          n_settings = 0;
  int          res_ok = 0;
  int          res_range = 0;
  int          res_past_end = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int unsigned cycles = 0;
  int unsigned cycle_limit = 20000;

  animation_frame_select dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic frame_req_t wr(input int unsigned idx, input logic anim,
                                    input logic [15:0] dur, input logic [15:0] loop_len,
                                    input logic [31:0] ftime);
    frame_req_t r;
    r.func = FUNC_WRITE;
    r.idx = 10'(idx);
    r.ftime = ftime;
    r.anim = anim;
    r.dur = dur;
    r.loop_len = loop_len;
    return r;
  endfunction

  // write-data bits of a lookup are set to show they are ignored
  function automatic frame_req_t lk(input int unsigned idx, input logic [31:0] ftime);
    frame_req_t r;
    r = '1;
    r.func = FUNC_LOOKUP;
    r.idx = 10'(idx);
    r.ftime = ftime;
    return r;
  endfunction

  // Predict a lookup; also flag a walk that would touch a never-written entry.
  function automatic walk_t select_frame(input logic [9:0] start, input logic [31:0] ftime);
    walk_t w;
    int unsigned lim;
    int unsigned pos;
    int unsigned rem;
    w = '0;
    w.res.status = ST_OK;
    lim = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
    if (start >= lim) begin
      w.res.status = ST_RANGE;
      return w;
    end
    if (!tbl_written[start]) w.unwritten = 1'b1;
    if (!tbl_anim[start] || tbl_loop[start] == 0) begin
      w.res.frame = start;
      return w;
    end
    rem = (ftime % tbl_loop[start]) / 8;
    pos = start;
    while (rem > tbl_dur[pos]) begin
      rem -= tbl_dur[pos];
      pos++;
      w.steps++;
      if (pos >= lim) begin
        w.res.status = ST_PAST_END;
        return w;
      end
      if (!tbl_written[pos]) w.unwritten = 1'b1;
    end
    w.res.frame = 10'(pos);
    return w;
  endfunction

  // Offer one beat, wait for it to be taken, then record its expected result.
  task automatic send_item(input frame_req_t req, input logic typed, input frame_res_t want);
    walk_t w;
    w = '0;
    s_tdata  <= {5'b0, req.loop_len, req.dur, req.anim, req.ftime, req.idx};
    s_tuser  <= req.func;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (req.func == FUNC_WRITE) begin
      tbl_anim[req.idx]    = req.anim;
      tbl_dur[req.idx]     = req.dur;
      tbl_loop[req.idx]    = req.loop_len;
      tbl_written[req.idx] = 1'b1;
      w.res = '{10'd0, ST_OK};
      n_writes++;
    end else begin
      w = select_frame(req.idx, req.ftime);
      n_lookups++;
    end
    expected_frames.push_back(typed ? want : w.res);
    cycle_limit += 400 + 8 * w.steps;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop lookups that would read an entry that was never written.
  task automatic offer_lookup(input int unsigned idx, input logic [31:0] ftime);
    frame_req_t req;
    walk_t w;
    req.func = FUNC_LOOKUP;
    req.idx = 10'(idx);
    req.ftime = ftime;
    req.anim = 1'($urandom_range(0, 1));
    req.dur = 16'($urandom_range(0, 65535));
    req.loop_len = 16'($urandom_range(0, 65535));
    w = select_frame(req.idx, req.ftime);
    if (!w.unwritten) send_item(req, 1'b0, '0);
  endtask

  // Only write the count once every result has drained.
  task automatic set_count(input logic [10:0] value);
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_count = value;
    n_settings++;
  endtask

  // result side: check each beat, then pick the next ready
  always @(posedge clk) begin
    frame_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_frames.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = expected_frames.pop_front();
          if (m_tdata[9:0] !== want.frame) begin
            errors++;
            $display("%0t: frame_index expected %0d actual %0d",
                     $time, want.frame, m_tdata[9:0]);
          end
          if (m_tdata[11:10] !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, m_tdata[11:10]);
          end
          case (want.status)
            ST_OK:    res_ok++;
            ST_RANGE: res_range++;
            default:  res_past_end++;
          endcase
        end
      end
      if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_limit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_frames.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned ph_count [6];
    int          ph_send  [6];
    int          ph_recv  [6];
    int          ph_items [6];
    int          ph;
    int          k;
    int          sent_at;
    int unsigned lim;
    int unsigned base;
    int unsigned len;
    int unsigned sum;
    int unsigned nlk;
    logic [15:0] head_dur;
    logic [15:0] head_loop;
    frame_req_t  req;

    dir_rows = '{
      '{ROW_TYPED,     lk(0, 0),                      '{10'd0, ST_RANGE}, 11'd0},
      '{ROW_TYPED,     lk(1023, 32'hFFFF_FFFF),       '{10'd0, ST_RANGE}, 11'd0},
      '{ROW_TYPED,     wr(0, 1'b1, 16'd3, 16'd64, 32'hFFFF_FFFF), '{10'd0, ST_OK}, 11'd0},
      '{ROW_TYPED,     wr(1, 1'b1, 16'd2, 16'd0, 32'd0),          '{10'd0, ST_OK}, 11'd0},
      '{ROW_TYPED,     wr(2, 1'b0, 16'd0, 16'd0, 32'd0),          '{10'd0, ST_OK}, 11'd0},
      '{ROW_TYPED,     wr(3, 1'b1, 16'd0, 16'd16, 32'd0),         '{10'd0, ST_OK}, 11'd0},
      '{ROW_TYPED,     wr(4, 1'b1, 16'hFFFF, 16'hFFFF, 32'd0),    '{10'd0, ST_OK}, 11'd0},
      '{ROW_TYPED,     wr(1023, 1'b1, 16'hFFFF, 16'hFFFF, 32'd0), '{10'd0, ST_OK}, 11'd0},
      '{ROW_COUNT,     '0,                            '0, 11'd3},
      '{ROW_TYPED,     lk(3, 0),                      '{10'd0, ST_RANGE}, 11'd0},
      '{ROW_PREDICTED, lk(0, 0),                      '0, 11'd0},
      '{ROW_PREDICTED, lk(0, 63),                     '0, 11'd0},
      '{ROW_PREDICTED, lk(0, 40),                     '0, 11'd0},
      '{ROW_TYPED,     lk(1, 12345),                  '{10'd1, ST_OK}, 11'd0},
      '{ROW_TYPED,     lk(2, 999),                    '{10'd2, ST_OK}, 11'd0},
      '{ROW_COUNT,     '0,                            '0, 11'd2047},
      '{ROW_PREDICTED, lk(0, 63),                     '0, 11'd0},
      '{ROW_PREDICTED, lk(3, 15),                     '0, 11'd0},
      '{ROW_PREDICTED, lk(4, 32'hFFFF_FFFE),          '0, 11'd0},
      '{ROW_PREDICTED, lk(1023, 32'hFFFF_FFFF),       '0, 11'd0},
      '{ROW_COUNT,     '0,                            '0, 11'd0},
      '{ROW_TYPED,     lk(0, 0),                      '{10'd0, ST_RANGE}, 11'd0}
    };

    ph_count = '{1024, 2047, $urandom_range(2, 1023), 40, 1, 1023};
    ph_send  = '{0, 84, 0, 13, 0, 0};
    ph_recv  = '{0, 0, 84, 13, 0, 0};
    ph_items = '{185, 185, 185, 185, 100, 185};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_COUNT)
        set_count(dir_rows[r].cfg);
      else
        send_item(dir_rows[r].req, dir_rows[r].kind == ROW_TYPED, dir_rows[r].exp);
    end

    for (ph = 0; ph < 6; ph++) begin
      set_count(11'(ph_count[ph]));
      send_idle_pct  = ph_send[ph];
      recv_stall_pct = ph_recv[ph];
      // last phase: long receiver hold while the sender keeps pushing
      if (ph == 5) begin
        hold_reqs++;
        cycle_limit += 2000;
      end
      sent_at = n_writes + n_lookups;
      while (n_writes + n_lookups - sent_at < ph_items[ph]) begin
        lim = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
        if ($urandom_range(0, 99) < 70) begin
          // animation sequence: followers first, head carries the loop length
          base = (lim > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, lim - 1)
                                                        : $urandom_range(0, TABLE_DEPTH - 1);
          len = $urandom_range(1, 8);
          if (base + len > TABLE_DEPTH) len = TABLE_DEPTH - base;
          sum = 0;
          for (k = len - 1; k >= 1; k--) begin
            req = wr(base + k, 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12)),
                     16'($urandom_range(0, 65535)), $urandom);
            sum += req.dur;
            send_item(req, 1'b0, '0);
          end
          head_dur = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
          sum += head_dur;
          case ($urandom_range(0, 9))
            0:       head_loop = 16'd0;
            1:       head_loop = 16'($urandom_range(1, 65535));
            default: head_loop = 16'(8 * sum + $urandom_range(0, 8 * len + 24));
          endcase
          send_item(wr(base, $urandom_range(0, 9) != 0, head_dur, head_loop, $urandom),
                    1'b0, '0);
          nlk = $urandom_range(2, 5);
          for (k = 0; k < nlk; k++)
            offer_lookup(($urandom_range(0, 3) == 0) ? base + $urandom_range(0, len - 1)
                                                     : base,
                         ($urandom_range(0, 4) == 0) ? $urandom
                                                     : $urandom_range(0, 3 * head_loop + 8));
        end else if ($urandom_range(0, 1) == 0) begin
          send_item(wr($urandom_range(0, TABLE_DEPTH - 1), 1'($urandom_range(0, 1)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       $urandom), 1'b0, '0);
        end else begin
          offer_lookup($urandom_range(0, TABLE_DEPTH - 1), $urandom);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Ran %0d writes and %0d lookups over %0d entry-count settings.",
             n_writes, n_lookups, n_settings);
    $display("Results: %0d ok, %0d start out of range, %0d walked off the end; %0d mismatches.",
             res_ok, res_range, res_past_end, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
